// ----- rtl/heading_hold_tank_drive_controller_macros.svh -----
// assertion macros for the heading hold drive controller
// used by the controller and datapath files, needs clk and arst_n in scope
`ifndef HEADING_HOLD_TANK_DRIVE_CONTROLLER_MACROS_SVH
`define HEADING_HOLD_TANK_DRIVE_CONTROLLER_MACROS_SVH

// checked only while out of reset
`define HHTD_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("%m: assertion failed");

// checked at every edge, reset included
`define HHTD_ASSERT_ALWAYS(label, prop) \
	label: assert property (@(posedge clk) prop) \
		else $error("%m: assertion failed");

`endif

// ----- rtl/hhtd_pkg.sv -----
// shared types, codes and angle helpers of the heading hold drive controller
// no dependencies
package hhtd_pkg;

	typedef logic [1:0]         cmd_code_t;
	typedef logic [2:0]         status_t;
	typedef logic [2:0]         reg_index_t;
	typedef logic [15:0]        reg_data_t;
	typedef logic signed [14:0] rpm_t;

	localparam cmd_code_t CMD_START    = 2'd0;
	localparam cmd_code_t CMD_TURN     = 2'd1;
	localparam cmd_code_t CMD_STRAIGHT = 2'd2;
	localparam cmd_code_t CMD_IDLE     = 2'd3;

	localparam status_t STAT_TURNING  = 3'd0;
	localparam status_t STAT_DONE     = 3'd1;
	localparam status_t STAT_TIMEOUT  = 3'd2;
	localparam status_t STAT_STRAIGHT = 3'd3;
	localparam status_t STAT_IDLE     = 3'd4;

	localparam reg_index_t REG_TURN_GAIN      = 3'd0;
	localparam reg_index_t REG_STRAIGHT_GAIN  = 3'd1;
	localparam reg_index_t REG_DEADBAND_SPEED = 3'd2;
	localparam reg_index_t REG_FINISH_SPEED   = 3'd3;
	localparam reg_index_t REG_MAX_SPEED      = 3'd4;
	localparam reg_index_t REG_DONE_TOLERANCE = 3'd5;
	localparam reg_index_t REG_MAX_RPM        = 3'd6;
	localparam reg_index_t REG_TIMEOUT_TICKS  = 3'd7;

	// centidegree angle constants
	localparam logic signed [17:0] HALF_TURN   = 18'sd18000;
	localparam logic signed [17:0] FULL_TURN   = 18'sd36000;
	localparam logic signed [17:0] TWO_TURNS   = 18'sd72000;
	localparam logic signed [17:0] THREE_TURNS = 18'sd108000;
	localparam logic signed [17:0] WRAP_LIM2   = 18'sd54000;
	localparam logic signed [17:0] WRAP_LIM3   = 18'sd90000;

	localparam logic [14:0] STRAIGHT_LIMIT = 15'd2000;
	localparam logic [32:0] ROUND_Q24      = 33'd256;
	localparam logic [32:0] ROUND_Q15      = 33'd16384;
	localparam logic [17:0] RPM_POS_MAX    = 18'd16383;
	localparam logic [17:0] RPM_NEG_MAG    = 18'd16384;

	typedef struct packed {
		logic [15:0] turn_gain;
		logic [15:0] straight_gain;
		logic [14:0] deadband_speed;
		logic [14:0] finish_speed;
		logic [14:0] max_speed;
		logic [14:0] done_tolerance;
		logic [12:0] max_rpm;
		logic [15:0] timeout_ticks;
	} hhtd_regs_t;

	// one step enable per sequencer state
	typedef struct packed {
		logic load_in;
		logic load_tgt;
		logic load_err;
		logic mul_gain;
		logic load_corr;
		logic mul_left;
		logic mul_right;
		logic load_out;
	} hhtd_cmd_t;

	// fold a target above a half turn into the gyro range
	function automatic logic signed [17:0] fold_angle(input logic signed [16:0] t);
		logic signed [17:0] tx;
		tx = 18'(t);
		return (tx <= HALF_TURN) ? tx : tx - FULL_TURN;
	endfunction

	// shortest-path wrap, input stays within three turns of zero
	function automatic logic signed [15:0] wrap_angle(input logic signed [17:0] e);
		logic signed [17:0] r;
		priority if (e > WRAP_LIM3) r = e - THREE_TURNS;
		else if (e > WRAP_LIM2) r = e - TWO_TURNS;
		else if (e > HALF_TURN) r = e - FULL_TURN;
		else if (e < -WRAP_LIM3) r = e + THREE_TURNS;
		else if (e < -WRAP_LIM2) r = e + TWO_TURNS;
		else if (e < -HALF_TURN) r = e + FULL_TURN;
		else r = e;
		return r[15:0];
	endfunction

endpackage

// ----- rtl/hhtd_ifs.sv -----
// valid/ready channel interfaces of the heading hold drive controller
// depends on hhtd_pkg
interface hhtd_in_if import hhtd_pkg::*; ();
	logic               valid;
	logic               ready;
	cmd_code_t          cmd;
	logic signed [16:0] target_angle;
	logic signed [15:0] heading;
	logic signed [15:0] speed;

	modport source (output valid, output cmd, output target_angle, output heading,
		output speed, input ready);
	modport sink (input valid, input cmd, input target_angle, input heading,
		input speed, output ready);
endinterface

interface hhtd_out_if import hhtd_pkg::*; ();
	logic    valid;
	logic    ready;
	rpm_t    left_rpm;
	rpm_t    right_rpm;
	status_t status;

	modport source (output valid, output left_rpm, output right_rpm, output status,
		input ready);
	modport sink (input valid, input left_rpm, input right_rpm, input status,
		output ready);
endinterface

interface hhtd_cfg_if import hhtd_pkg::*; ();
	logic       valid;
	logic       ready;
	reg_index_t index;
	reg_data_t  data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ----- rtl/hhtd_cfg.sv -----
// configuration register file of the heading hold drive controller
// depends on hhtd_pkg and hhtd_cfg_if
module hhtd_cfg import hhtd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	hhtd_cfg_if.sink    cfg,
	output hhtd_regs_t  regs
);

	hhtd_regs_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.turn_gain      <= 16'd1342;
			regs_q.straight_gain  <= 16'd1342;
			regs_q.deadband_speed <= 15'd1638;
			regs_q.finish_speed   <= 15'd6554;
			regs_q.max_speed      <= 15'd26214;
			regs_q.done_tolerance <= 15'd200;
			regs_q.max_rpm        <= 13'd5000;
			regs_q.timeout_ticks  <= 16'd150;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_TURN_GAIN:      regs_q.turn_gain      <= cfg.data;
				REG_STRAIGHT_GAIN:  regs_q.straight_gain  <= cfg.data;
				REG_DEADBAND_SPEED: regs_q.deadband_speed <= cfg.data[14:0];
				REG_FINISH_SPEED:   regs_q.finish_speed   <= cfg.data[14:0];
				REG_MAX_SPEED:      regs_q.max_speed      <= cfg.data[14:0];
				REG_DONE_TOLERANCE: regs_q.done_tolerance <= cfg.data[14:0];
				REG_MAX_RPM:        regs_q.max_rpm        <= cfg.data[12:0];
				REG_TIMEOUT_TICKS:  regs_q.timeout_ticks  <= cfg.data;
			endcase
		end
	end

endmodule

// ----- rtl/hhtd_ctrl.sv -----
// sequencer of the heading hold drive controller: handshakes and step enables
// depends on hhtd_pkg and the assertion macro header
`include "heading_hold_tank_drive_controller_macros.svh"

module hhtd_ctrl import hhtd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	output hhtd_cmd_t ctl
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_TGT  = 3'd1;
	localparam logic [2:0] S_ERR  = 3'd2;
	localparam logic [2:0] S_GAIN = 3'd3;
	localparam logic [2:0] S_CORR = 3'd4;
	localparam logic [2:0] S_RPML = 3'd5;
	localparam logic [2:0] S_RPMR = 3'd6;
	localparam logic [2:0] S_FIN  = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;
	logic       out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		ctl     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					ctl.load_in = 1'b1;
					state_d     = S_TGT;
				end
			end
			S_TGT: begin
				ctl.load_tgt = 1'b1;
				state_d      = S_ERR;
			end
			S_ERR: begin
				ctl.load_err = 1'b1;
				state_d      = S_GAIN;
			end
			S_GAIN: begin
				ctl.mul_gain = 1'b1;
				state_d      = S_CORR;
			end
			S_CORR: begin
				ctl.load_corr = 1'b1;
				state_d       = S_RPML;
			end
			S_RPML: begin
				ctl.mul_left = 1'b1;
				state_d      = S_RPMR;
			end
			S_RPMR: begin
				ctl.mul_right = 1'b1;
				state_d       = S_FIN;
			end
			S_FIN: begin
				// hold until the output register is free or its transfer completes
				if (out_free) begin
					ctl.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`HHTD_ASSERT(a_one_step, $onehot0(ctl))
	`HHTD_ASSERT(a_accept_starts, (in_valid && in_ready) |=> (state_q == S_TGT))
	`HHTD_ASSERT(a_fixed_latency, (in_valid && in_ready && !out_valid_q) |-> ##7 ctl.load_out)
	`HHTD_ASSERT_ALWAYS(a_reset_idle, !arst_n |-> (state_q == S_IDLE && !out_valid_q))

endmodule

// ----- rtl/hhtd_dp.sv -----
// datapath of the heading hold drive controller: angle error, shared multiplier,
// correction shaping, rpm scaling and turn state; depends on hhtd_pkg and the macro header
`include "heading_hold_tank_drive_controller_macros.svh"

module hhtd_dp import hhtd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  hhtd_cmd_t          ctl,
	input  hhtd_regs_t         regs,
	input  cmd_code_t          in_cmd,
	input  logic signed [16:0] in_target_angle,
	input  logic signed [15:0] in_heading,
	input  logic signed [15:0] in_speed,
	output rpm_t               left_rpm,
	output rpm_t               right_rpm,
	output status_t            status
);

	// item registers
	cmd_code_t          op_q;
	logic signed [16:0] tgt_q;
	logic signed [15:0] hdg_q;
	logic signed [15:0] spd_q;
	logic signed [17:0] base_q;
	logic signed [15:0] err_q;
	logic [31:0]        prod_q;
	logic signed [16:0] left_x_q;
	logic signed [16:0] right_x_q;
	status_t            stat_q;
	rpm_t               left_rpm_q;
	rpm_t               out_left_q;
	rpm_t               out_right_q;
	status_t            out_status_q;

	// turn state
	logic               turn_active_q;
	logic [15:0]        tick_q;
	logic signed [15:0] latched_q;

	logic signed [17:0] fold_t;
	logic signed [15:0] wrap_t;
	logic signed [17:0] diff;
	logic [14:0]        err_mag;
	logic [15:0]        left_mag;
	logic [15:0]        right_mag;
	logic [15:0]        mul_a;
	logic [15:0]        mul_b;
	logic [31:0]        prod_d;
	logic [32:0]        rnd;
	logic [23:0]        mag;
	logic [14:0]        corr_mag;
	logic signed [15:0] corr;
	logic signed [16:0] corr_x;
	logic signed [16:0] spd_x;
	logic               is_turn;
	logic               timed_out;
	logic               turn_end;
	logic               far;

	function automatic rpm_t to_rpm(input logic [31:0] p, input logic neg, input logic zero);
		logic [32:0] s;
		logic [17:0] r;
		logic [17:0] n;
		rpm_t        res;
		s = {1'b0, p} + ROUND_Q15;
		r = s[32:15];
		priority if (zero) begin
			res = '0;
		end else if (neg) begin
			if (r > RPM_NEG_MAG) r = RPM_NEG_MAG;
			n   = -r;
			res = n[14:0];
		end else begin
			res = (r > RPM_POS_MAX) ? RPM_POS_MAX[14:0] : r[14:0];
		end
		return res;
	endfunction

	assign fold_t    = fold_angle(tgt_q);
	assign wrap_t    = wrap_angle(fold_t);
	assign diff      = base_q - 18'(hdg_q);
	assign err_mag   = err_q[15] ? 15'(-err_q) : err_q[14:0];
	assign left_mag  = left_x_q[16] ? 16'(-left_x_q) : left_x_q[15:0];
	assign right_mag = right_x_q[16] ? 16'(-right_x_q) : right_x_q[15:0];
	assign is_turn   = (op_q == CMD_START) || (op_q == CMD_TURN);
	assign timed_out = (tick_q >= regs.timeout_ticks);
	assign turn_end  = (err_mag <= regs.done_tolerance) || timed_out;
	assign far       = (err_mag > STRAIGHT_LIMIT);

	// one multiplier shared by the gain step and both rpm steps
	always_comb begin
		priority if (ctl.mul_left) begin
			mul_a = left_mag;
			mul_b = {3'b0, regs.max_rpm};
		end else if (ctl.mul_right) begin
			mul_a = right_mag;
			mul_b = {3'b0, regs.max_rpm};
		end else begin
			mul_a = {1'b0, err_mag};
			mul_b = (op_q == CMD_STRAIGHT) ? regs.straight_gain : regs.turn_gain;
		end
	end
	assign prod_d = 32'(mul_a) * 32'(mul_b);

	// q24 to q15 with rounding, then finish boost and max clamp
	assign rnd = {1'b0, prod_q} + ROUND_Q24;
	assign mag = rnd[32:9];
	always_comb begin
		priority if (mag > {9'b0, regs.max_speed}) begin
			corr_mag = regs.max_speed;
		end else if (mag > {9'b0, regs.deadband_speed} && mag < {9'b0, regs.finish_speed}) begin
			corr_mag = regs.finish_speed;
		end else begin
			corr_mag = mag[14:0];
		end
	end
	assign corr   = err_q[15] ? -$signed({1'b0, corr_mag}) : $signed({1'b0, corr_mag});
	assign corr_x = 17'(corr);
	assign spd_x  = 17'(spd_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			turn_active_q <= 1'b0;
			tick_q        <= '0;
			latched_q     <= '0;
		end else begin
			if (ctl.load_tgt && op_q == CMD_START) begin
				latched_q     <= wrap_t;
				tick_q        <= '0;
				turn_active_q <= 1'b1;
			end
			if (ctl.load_corr && is_turn && turn_active_q) begin
				if (turn_end) begin
					turn_active_q <= 1'b0;
				end else if (tick_q != '1) begin
					tick_q <= tick_q + 16'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_in) begin
			op_q  <= in_cmd;
			tgt_q <= in_target_angle;
			hdg_q <= in_heading;
			spd_q <= in_speed;
		end
		if (ctl.load_tgt) begin
			unique case (op_q)
				CMD_START:    base_q <= 18'(wrap_t);
				CMD_TURN:     base_q <= 18'(latched_q);
				CMD_STRAIGHT: base_q <= fold_t;
				CMD_IDLE:     base_q <= fold_t;
			endcase
		end
		if (ctl.load_err) begin
			err_q <= wrap_angle(diff);
		end
		if (ctl.mul_gain || ctl.mul_left || ctl.mul_right) begin
			prod_q <= prod_d;
		end
		if (ctl.load_corr) begin
			unique case (op_q)
				CMD_START, CMD_TURN: begin
					if (!turn_active_q) begin
						left_x_q  <= '0;
						right_x_q <= '0;
						stat_q    <= STAT_IDLE;
					end else if (turn_end) begin
						left_x_q  <= '0;
						right_x_q <= '0;
						stat_q    <= timed_out ? STAT_TIMEOUT : STAT_DONE;
					end else begin
						left_x_q  <= corr_x;
						right_x_q <= -corr_x;
						stat_q    <= STAT_TURNING;
					end
				end
				CMD_STRAIGHT: begin
					// large errors spin in place, small ones ride on the base speed
					if (far) begin
						left_x_q  <= corr_x;
						right_x_q <= -corr_x;
					end else begin
						left_x_q  <= spd_x + corr_x;
						right_x_q <= spd_x - corr_x;
					end
					stat_q <= STAT_STRAIGHT;
				end
				CMD_IDLE: begin
					left_x_q  <= '0;
					right_x_q <= '0;
					stat_q    <= STAT_IDLE;
				end
			endcase
		end
		if (ctl.mul_right) begin
			left_rpm_q <= to_rpm(prod_q, left_x_q[16], left_mag <= {1'b0, regs.deadband_speed});
		end
		if (ctl.load_out) begin
			out_left_q   <= left_rpm_q;
			out_right_q  <= to_rpm(prod_q, right_x_q[16],
				right_mag <= {1'b0, regs.deadband_speed});
			out_status_q <= stat_q;
		end
	end

	assign left_rpm  = out_left_q;
	assign right_rpm = out_right_q;
	assign status    = out_status_q;

	`HHTD_ASSERT(a_err_wrapped, ctl.load_err |=> (err_q <= HALF_TURN && err_q >= -HALF_TURN))
	`HHTD_ASSERT(a_latched_range, latched_q <= HALF_TURN && latched_q >= -HALF_TURN)
	`HHTD_ASSERT(a_turn_ends, (ctl.load_corr && is_turn && turn_active_q && turn_end) |=> !turn_active_q)

endmodule

// ----- rtl/heading_hold_tank_drive_controller.sv -----
// Heading hold controller for a two-sided drive. Each input transfer carries one command
// (start turn, turn tick, straight tick or idle) and yields exactly one output transfer with
// left and right rpm and a status code. An accepted item runs a 7-step sequence before the
// next input transfer can be taken, a sequence whose steps are set by the use of one
// 16x16 multiplier that is used in turn for the gain product and for the left and right rpm
// scaling. The result sits in an output register, so the next item is taken while it waits;
// a stalled output only holds the sequencer at its last step. Configuration registers are
// written through their own channel, one per transfer, and should only change while idle.
// depends on hhtd_pkg, the channel interfaces, hhtd_cfg, hhtd_ctrl and hhtd_dp
module heading_hold_tank_drive_controller import hhtd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	hhtd_in_if.sink   in_ch,
	hhtd_out_if.source out_ch,
	hhtd_cfg_if.sink  cfg
);

	hhtd_regs_t regs;
	hhtd_cmd_t  ctl;

	hhtd_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	hhtd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.ctl       (ctl)
	);

	hhtd_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.ctl             (ctl),
		.regs            (regs),
		.in_cmd          (in_ch.cmd),
		.in_target_angle (in_ch.target_angle),
		.in_heading      (in_ch.heading),
		.in_speed        (in_ch.speed),
		.left_rpm        (out_ch.left_rpm),
		.right_rpm       (out_ch.right_rpm),
		.status          (out_ch.status)
	);

endmodule
